### design/asfp_pkg.sv
// Package for the actuator status frame parser.
// Holds the widths, frame positions, register indexes and the queue entry type.
// No dependencies.
package asfp_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;
    localparam int POS_W = 9;
    localparam int STATUS_BYTES = 12;
    localparam int NUM_WORDS = 6;
    localparam int FIRST_STATUS_POS = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [POS_W-1:0] POS_HUNT = 9'd0;
    localparam logic [POS_W-1:0] POS_HEADER_SECOND = 9'd1;
    localparam logic [POS_W-1:0] POS_LENGTH = 9'd2;
    localparam logic [POS_W-1:0] POS_ID = 9'd3;
    localparam logic [POS_W-1:0] POS_CMD = 9'd4;
    localparam logic [POS_W-1:0] LENGTH_OFFSET = 9'd4;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_FIRST = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CMD_READ_STATUS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CMD_WRITE_REGISTER = 2'd3;

    localparam logic [BYTE_W-1:0] RESET_HEADER_FIRST = 8'hAA;
    localparam logic [BYTE_W-1:0] RESET_HEADER_SECOND = 8'h55;
    localparam logic [BYTE_W-1:0] RESET_CMD_READ_STATUS = 8'h30;
    localparam logic [BYTE_W-1:0] RESET_CMD_WRITE_REGISTER = 8'h32;

    typedef logic [STATUS_BYTES-1:0][BYTE_W-1:0] asfp_status_t;

    typedef struct packed {
        logic         updated;
        logic [BYTE_W-1:0] id;
        asfp_status_t status;
    } asfp_entry_t;

endpackage

### design/asfp_front.sv
// Front part of the actuator status frame parser: configuration registers and
// the per-byte frame parser that pushes each good frame into the queue.
// Depends on asfp_pkg.
module asfp_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [asfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [asfp_pkg::BYTE_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [asfp_pkg::BYTE_W-1:0]         rx_byte,
    input  logic                                burst_start,
    input  logic                                q_full,
    output logic                                q_push,
    output asfp_pkg::asfp_entry_t               q_entry
);

    logic [asfp_pkg::BYTE_W-1:0] hdr_first_reg;
    logic [asfp_pkg::BYTE_W-1:0] hdr_second_reg;
    logic [asfp_pkg::BYTE_W-1:0] cmd_read_reg;
    logic [asfp_pkg::BYTE_W-1:0] cmd_write_reg;

    logic [asfp_pkg::POS_W-1:0]  pos_reg, pos_next, pos_eff;
    logic [asfp_pkg::BYTE_W-1:0] len_reg, len_next, len_eff;
    logic [asfp_pkg::BYTE_W-1:0] sum_reg, sum_next, sum_eff;
    logic [asfp_pkg::BYTE_W-1:0] id_reg, id_next;
    logic [asfp_pkg::BYTE_W-1:0] cmd_reg, cmd_next;
    asfp_pkg::asfp_status_t      status_reg, status_next;
    logic                        accept;
    logic                        good_frame;

    assign in_stall = q_full;
    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg <= asfp_pkg::RESET_HEADER_FIRST;
            hdr_second_reg <= asfp_pkg::RESET_HEADER_SECOND;
            cmd_read_reg <= asfp_pkg::RESET_CMD_READ_STATUS;
            cmd_write_reg <= asfp_pkg::RESET_CMD_WRITE_REGISTER;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                asfp_pkg::CFG_HEADER_FIRST:       hdr_first_reg <= cfg_data;
                asfp_pkg::CFG_HEADER_SECOND:      hdr_second_reg <= cfg_data;
                asfp_pkg::CFG_CMD_READ_STATUS:    cmd_read_reg <= cfg_data;
                asfp_pkg::CFG_CMD_WRITE_REGISTER: cmd_write_reg <= cfg_data;
                default:                          hdr_first_reg <= hdr_first_reg;
            endcase
        end
    end

    always_comb
    begin
        pos_eff = burst_start ? asfp_pkg::POS_HUNT : pos_reg;
        len_eff = burst_start ? '0 : len_reg;
        sum_eff = burst_start ? '0 : sum_reg;
        pos_next = pos_eff;
        len_next = len_eff;
        sum_next = sum_eff;
        id_next = id_reg;
        cmd_next = cmd_reg;
        status_next = status_reg;
        good_frame = 1'b0;
        if (pos_eff == asfp_pkg::POS_HUNT)
        begin
            if (rx_byte == hdr_first_reg)
            begin
                pos_next = asfp_pkg::POS_HEADER_SECOND;
            end
        end
        else if (pos_eff == asfp_pkg::POS_HEADER_SECOND)
        begin
            if (rx_byte == hdr_second_reg)
            begin
                pos_next = asfp_pkg::POS_LENGTH;
            end
        end
        else if (pos_eff == asfp_pkg::POS_LENGTH)
        begin
            len_next = rx_byte;
            sum_next = rx_byte;
            pos_next = asfp_pkg::POS_ID;
        end
        else if (pos_eff == asfp_pkg::POS_ID)
        begin
            id_next = rx_byte;
            sum_next = sum_eff + rx_byte;
            pos_next = asfp_pkg::POS_CMD;
        end
        else
        begin
            if (pos_eff == asfp_pkg::POS_CMD)
            begin
                cmd_next = rx_byte;
            end
            for (int k = 0; k < asfp_pkg::STATUS_BYTES; k++)
            begin
                if (pos_eff == asfp_pkg::POS_W'(asfp_pkg::FIRST_STATUS_POS + k))
                begin
                    status_next[k] = rx_byte;
                end
            end
            if (pos_eff != ({1'b0, len_eff} + asfp_pkg::LENGTH_OFFSET))
            begin
                sum_next = sum_eff + rx_byte;
                pos_next = pos_eff + 1'b1;
            end
            else
            begin
                pos_next = asfp_pkg::POS_HUNT;
                good_frame = (sum_eff == rx_byte);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
            sum_reg <= '0;
            id_reg <= '0;
            cmd_reg <= '0;
            status_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            sum_reg <= sum_next;
            id_reg <= id_next;
            cmd_reg <= cmd_next;
            status_reg <= status_next;
        end
    end

    assign q_push = accept && good_frame;
    assign q_entry.updated = (cmd_next == cmd_read_reg) || (cmd_next == cmd_write_reg);
    assign q_entry.id = id_next;
    assign q_entry.status = status_next;

endmodule

### design/asfp_queue.sv
// Short result queue between the parser front and the output back part.
// Register-based ring buffer of asfp_entry_t items. Depends on asfp_pkg.
module asfp_queue
#(
    parameter int DEPTH = asfp_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  asfp_pkg::asfp_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output asfp_pkg::asfp_entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    asfp_pkg::asfp_entry_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("Item pushed into a full queue.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("Item popped from an empty queue.");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Queue count did not follow a push.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Queue count beyond depth.");

endmodule

### design/asfp_back.sv
// Back part of the actuator status frame parser: holds the reported status
// words and the output register of the result channel. Depends on asfp_pkg.
module asfp_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_not_empty,
    input  asfp_pkg::asfp_entry_t        q_entry,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         status_updated,
    output logic [asfp_pkg::BYTE_W-1:0]  responder_id,
    output logic [asfp_pkg::NUM_WORDS-1:0][asfp_pkg::WORD_W-1:0] words
);

    logic                        out_valid_reg;
    logic                        updated_reg;
    logic [asfp_pkg::BYTE_W-1:0] id_reg;
    logic [asfp_pkg::NUM_WORDS-1:0][asfp_pkg::WORD_W-1:0] words_reg, words_next;

    assign q_pop = q_not_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        for (int k = 0; k < asfp_pkg::NUM_WORDS; k++)
        begin
            words_next[k] = {q_entry.status[2 * k + 1], q_entry.status[2 * k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            words_reg <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                if (q_entry.updated)
                begin
                    words_reg <= words_next;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            updated_reg <= q_entry.updated;
            id_reg <= q_entry.id;
        end
    end

    assign out_valid = out_valid_reg;
    assign status_updated = updated_reg;
    assign responder_id = id_reg;
    assign words = words_reg;

endmodule

### design/actuator_status_frame_parser.sv
// Top level of the actuator status frame parser.
// Connects asfp_front, asfp_queue and asfp_back. Depends on asfp_pkg.
//
// The block takes one received byte per clock cycle on the input channel, while
// in_stall is low, and reports one result for each frame whose checksum is good.
// Every byte is parsed in the cycle in which it is accepted; a good frame's
// result enters a queue of QUEUE_DEPTH items and moves from there into the
// output register when the output side is free. The input stalls only while
// the queue is full, which happens only when the output side has stalled long
// enough for that many results to pile up. The user must write the four header
// and command codes on the configuration port only while the block is idle; the
// block itself does not enforce this.
module actuator_status_frame_parser
#(
    parameter int QUEUE_DEPTH = asfp_pkg::QUEUE_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [asfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [asfp_pkg::BYTE_W-1:0]      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [asfp_pkg::BYTE_W-1:0]      rx_byte,
    input  logic                             burst_start,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             status_updated,
    output logic [asfp_pkg::BYTE_W-1:0]      responder_id,
    output logic [asfp_pkg::WORD_W-1:0]      position,
    output logic [asfp_pkg::WORD_W-1:0]      motor_current,
    output logic [asfp_pkg::WORD_W-1:0]      force_res,
    output logic [asfp_pkg::WORD_W-1:0]      speed,
    output logic [asfp_pkg::WORD_W-1:0]      error_word,
    output logic [asfp_pkg::WORD_W-1:0]      temperature
);

    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_not_empty;
    asfp_pkg::asfp_entry_t push_entry;
    asfp_pkg::asfp_entry_t head_entry;
    logic [asfp_pkg::NUM_WORDS-1:0][asfp_pkg::WORD_W-1:0] words;

    asfp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .burst_start (burst_start),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    asfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_entry (head_entry)
    );

    asfp_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_entry        (head_entry),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status_updated (status_updated),
        .responder_id   (responder_id),
        .words          (words)
    );

    assign position = words[0];
    assign motor_current = words[1];
    assign force_res = words[2];
    assign speed = words[3];
    assign error_word = words[4];
    assign temperature = words[5];

endmodule

### sim/tb_actuator_status_frame_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for actuator_status_frame_parser: random byte bursts against a
// stalling receiver, each report checked against a frame parser kept inside the bench.
// Depends on asfp_pkg and the parser RTL.
module tb_actuator_status_frame_parser;
    import asfp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BYTES = 120;
    localparam int FULL_FRAME = 1000;

    typedef enum logic [1:0] {FILL_RANDOM, FILL_ONES, FILL_ZEROS} payload_fill_t;
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_stall_mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              burst;
    } rx_item_t;

    typedef struct packed {
        logic                               updated;
        logic [BYTE_W-1:0]                  id;
        logic [NUM_WORDS-1:0][WORD_W-1:0]   words;
    } status_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_HEADER_FIRST;
    logic [BYTE_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [BYTE_W-1:0]      rx_byte = '0;
    logic                   burst_start = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   status_updated;
    logic [BYTE_W-1:0]      responder_id;
    logic [WORD_W-1:0]      position;
    logic [WORD_W-1:0]      motor_current;
    logic [WORD_W-1:0]      force_res;
    logic [WORD_W-1:0]      speed;
    logic [WORD_W-1:0]      error_word;
    logic [WORD_W-1:0]      temperature;

    logic [BYTE_W-1:0] hdr_first_cfg = RESET_HEADER_FIRST;
    logic [BYTE_W-1:0] hdr_second_cfg = RESET_HEADER_SECOND;
    logic [BYTE_W-1:0] cmd_read_cfg = RESET_CMD_READ_STATUS;
    logic [BYTE_W-1:0] cmd_write_cfg = RESET_CMD_WRITE_REGISTER;

    logic [POS_W-1:0]                     parse_pos = '0;
    logic [BYTE_W-1:0]                    parse_len = '0;
    logic [BYTE_W-1:0]                    parse_sum = '0;
    logic [BYTE_W-1:0]                    parse_id = '0;
    logic [BYTE_W-1:0]                    parse_cmd = '0;
    logic [STATUS_BYTES-1:0][BYTE_W-1:0]  status_shadow = '0;
    logic [NUM_WORDS-1:0][WORD_W-1:0]     word_shadow = '0;

    rx_item_t       pending_bytes[$];
    status_report_t expected_reports[$];
    rx_item_t       next_item;
    status_report_t observed;
    string          word_names[NUM_WORDS] = '{"position", "motor_current", "force_res",
                                              "speed", "error_word", "temperature"};

    int errors = 0;
    int cycles = 0;
    int queued_bytes = 0;
    int bytes_taken = 0;
    int reports_seen = 0;
    int updates_seen = 0;
    int in_stall_cycles = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    int mode_left = 0;
    int stall_phase = 0;
    bit in_took = 1'b0;
    bit hold_req = 1'b0;
    bit stall_next = 1'b0;
    rx_stall_mode_t rx_mode = RX_FREE;

    actuator_status_frame_parser u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .burst_start    (burst_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status_updated (status_updated),
        .responder_id   (responder_id),
        .position       (position),
        .motor_current  (motor_current),
        .force_res      (force_res),
        .speed          (speed),
        .error_word     (error_word),
        .temperature    (temperature)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic parse_rx_byte(input logic [BYTE_W-1:0] b, input logic clear);
        logic [POS_W-1:0] p;
        status_report_t   r;
        int               k;
        if (clear)
        begin
            parse_pos = POS_HUNT;
            parse_len = '0;
            parse_sum = '0;
        end
        p = parse_pos;
        if (p == POS_HUNT)
        begin
            if (b == hdr_first_cfg)
                parse_pos = POS_HEADER_SECOND;
        end
        else if (p == POS_HEADER_SECOND)
        begin
            if (b == hdr_second_cfg)
                parse_pos = POS_LENGTH;
        end
        else if (p == POS_LENGTH)
        begin
            parse_len = b;
            parse_sum = b;
            parse_pos = POS_ID;
        end
        else if (p == POS_ID)
        begin
            parse_id = b;
            parse_sum = parse_sum + b;
            parse_pos = POS_CMD;
        end
        else
        begin
            if (p == POS_CMD)
                parse_cmd = b;
            if (p >= FIRST_STATUS_POS && p < FIRST_STATUS_POS + STATUS_BYTES)
                status_shadow[p - FIRST_STATUS_POS] = b;
            if (p != {1'b0, parse_len} + LENGTH_OFFSET)
            begin
                parse_sum = parse_sum + b;
                parse_pos = p + 1'b1;
            end
            else
            begin
                parse_pos = POS_HUNT;
                if (parse_sum == b)
                begin
                    r.updated = (parse_cmd == cmd_read_cfg) || (parse_cmd == cmd_write_cfg);
                    if (r.updated)
                        for (k = 0; k < NUM_WORDS; k++)
                            word_shadow[k] = {status_shadow[2*k+1], status_shadow[2*k]};
                    r.id = parse_id;
                    r.words = word_shadow;
                    expected_reports.push_back(r);
                end
            end
        end
    endtask

    task automatic check_report(input status_report_t got);
        status_report_t want;
        int             k;
        if (expected_reports.size() == 0)
        begin
            report_mismatch($sformatf("report %0d with id %h arrived with none expected",
                                      reports_seen, got.id));
        end
        else
        begin
            want = expected_reports.pop_front();
            if (got.updated !== want.updated)
                report_mismatch($sformatf("report %0d status_updated: got %b, want %b",
                                          reports_seen, got.updated, want.updated));
            if (got.id !== want.id)
                report_mismatch($sformatf("report %0d responder_id: got %h, want %h",
                                          reports_seen, got.id, want.id));
            for (k = 0; k < NUM_WORDS; k++)
                if (got.words[k] !== want.words[k])
                    report_mismatch($sformatf("report %0d %s: got %h, want %h", reports_seen,
                                              word_names[k], got.words[k], want.words[k]));
        end
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout: run stopped after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Prediction runs before checking so that a report can never overtake its own item.
    always @(posedge clk)
    begin
        in_took = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_stall)
                in_stall_cycles++;
            if (in_valid && !in_stall)
            begin
                in_took = 1'b1;
                bytes_taken++;
                parse_rx_byte(rx_byte, burst_start);
            end
            if (out_valid && !out_stall)
            begin
                reports_seen++;
                if (status_updated === 1'b1)
                    updates_seen++;
                observed.updated = status_updated;
                observed.id = responder_id;
                observed.words = {temperature, error_word, speed, force_res, motor_current,
                                  position};
                check_report(observed);
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (gap_left > 0 || pending_bytes.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                next_item = pending_bytes.pop_front();
                in_valid <= 1'b1;
                rx_byte <= next_item.data;
                burst_start <= next_item.burst;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 10);
                    gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_req = 1'b0;
        end
        if (mode_left == 0)
        begin
            rx_mode = rx_stall_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 200);
        end
        else
            mode_left--;
        stall_phase++;
        if (hold_left > 0)
        begin
            hold_left--;
            stall_next = 1'b1;
        end
        else
        begin
            case (rx_mode)
                RX_FREE:  stall_next = 1'b0;
                RX_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
                RX_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
                default:  stall_next = (stall_phase % 7) < 3;
            endcase
        end
        out_stall <= stall_next;
    end

    task automatic add_byte(input logic [BYTE_W-1:0] b, input logic bs);
        rx_item_t it;
        it.data = b;
        it.burst = bs;
        pending_bytes.push_back(it);
        queued_bytes++;
    endtask

    task automatic add_frame(input int len, input logic [BYTE_W-1:0] id,
                             input logic [BYTE_W-1:0] cmd, input payload_fill_t fill,
                             input bit corrupt, input bit bs, input int cut);
        logic [BYTE_W-1:0] frame_bytes[$];
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int                i;
        frame_bytes.push_back(hdr_first_cfg);
        frame_bytes.push_back(hdr_second_cfg);
        frame_bytes.push_back(BYTE_W'(len));
        frame_bytes.push_back(id);
        sum = BYTE_W'(len) + id;
        for (i = 0; i < len; i++)
        begin
            case (fill)
                FILL_ONES:  b = '1;
                FILL_ZEROS: b = '0;
                default:    b = BYTE_W'($urandom);
            endcase
            if (i == 0)
                b = cmd;
            frame_bytes.push_back(b);
            sum = sum + b;
        end
        if (corrupt)
            sum = sum + BYTE_W'($urandom_range(1, 255));
        frame_bytes.push_back(sum);
        for (i = 0; i < frame_bytes.size() && i < cut; i++)
            add_byte(frame_bytes[i], bs && i == 0);
    endtask

    task automatic add_random_traffic(input int n_bytes);
        int                first;
        int                kind;
        int                len;
        int                pick;
        bit                dirty;
        logic [BYTE_W-1:0] cmd;
        first = queued_bytes;
        dirty = 1'b0;
        while (queued_bytes - first < n_bytes)
        begin
            kind = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            len = (pick < 50) ? $urandom_range(0, 15) :
                  (pick < 85) ? $urandom_range(14, 20) : $urandom_range(21, 40);
            pick = $urandom_range(0, 9);
            cmd = (pick < 4) ? cmd_read_cfg : (pick < 7) ? cmd_write_cfg : BYTE_W'($urandom);
            if (kind < 70)
            begin
                add_frame(len, BYTE_W'($urandom), cmd, FILL_RANDOM, $urandom_range(0, 99) < 15,
                          dirty ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 3) == 0),
                          FULL_FRAME);
                dirty = 1'b0;
            end
            else if (kind < 85)
            begin
                repeat ($urandom_range(1, 6))
                    add_byte(($urandom_range(0, 3) == 0) ? hdr_first_cfg : BYTE_W'($urandom),
                             $urandom_range(0, 4) == 0);
                dirty = 1'b1;
            end
            else
            begin
                add_frame(len, BYTE_W'($urandom), cmd, FILL_RANDOM, 1'b0,
                          $urandom_range(0, 1) == 1, $urandom_range(1, len + 4));
                dirty = 1'b1;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            CFG_HEADER_FIRST:    hdr_first_cfg = value;
            CFG_HEADER_SECOND:   hdr_second_cfg = value;
            CFG_CMD_READ_STATUS: cmd_read_cfg = value;
            default:             cmd_write_cfg = value;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_config(input logic [BYTE_W-1:0] h1, input logic [BYTE_W-1:0] h2,
                              input logic [BYTE_W-1:0] cr, input logic [BYTE_W-1:0] cw);
        write_reg(CFG_HEADER_FIRST, h1);
        write_reg(CFG_HEADER_SECOND, h2);
        write_reg(CFG_CMD_READ_STATUS, cr);
        write_reg(CFG_CMD_WRITE_REGISTER, cw);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A stray byte while waiting for the second header byte, then a repeated first header
        // byte that opens a frame whose checksum lands on the last status byte.
        add_byte(hdr_first_cfg, 1'b0);
        add_byte(8'h00, 1'b0);
        add_frame(14, 8'hFF, cmd_read_cfg, FILL_ONES, 1'b0, 1'b0, FULL_FRAME);
        add_frame(5, 8'h00, cmd_write_cfg, FILL_ZEROS, 1'b0, 1'b0, FULL_FRAME);
        add_frame(0, cmd_write_cfg, 8'h00, FILL_RANDOM, 1'b0, 1'b0, FULL_FRAME);
        add_frame(3, 8'h11, cmd_read_cfg, FILL_RANDOM, 1'b0, 1'b0, 4);
        add_frame(1, 8'h22, cmd_read_cfg, FILL_RANDOM, 1'b1, 1'b1, FULL_FRAME);
        add_frame(2, 8'h33, cmd_read_cfg, FILL_RANDOM, 1'b0, 1'b0, FULL_FRAME);
        wait_idle();

        set_config(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        add_random_traffic(PHASE_BYTES);
        wait_idle();

        set_config(8'h00, 8'hFF, 8'h00, 8'hFF);
        add_random_traffic(PHASE_BYTES);
        wait_idle();

        set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        add_random_traffic(PHASE_BYTES);
        wait_idle();

        set_config(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        hold_req = 1'b1;
        repeat (16)
            add_frame($urandom_range(0, 3), BYTE_W'($urandom), cmd_read_cfg, FILL_RANDOM,
                      1'b0, 1'b0, FULL_FRAME);
        add_frame(255, BYTE_W'($urandom), cmd_write_cfg, FILL_RANDOM, 1'b0, 1'b1, FULL_FRAME);
        add_frame($urandom_range(252, 254), BYTE_W'($urandom), cmd_read_cfg, FILL_RANDOM,
                  1'b0, 1'b0, FULL_FRAME);
        add_random_traffic(PHASE_BYTES / 2);
        wait_idle();

        repeat (8) @(posedge clk);
        if (expected_reports.size() != 0)
            report_mismatch($sformatf("%0d expected reports never arrived",
                                      expected_reports.size()));
        $display("Summary: %0d bytes parsed, %0d reports checked, %0d with fresh status words.",
                 bytes_taken, reports_seen, updates_seen);
        $display("Summary: five register settings, input held off on %0d cycles.",
                 in_stall_cycles);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### actuator_status_frame_parser.f
design/asfp_pkg.sv
design/asfp_front.sv
design/asfp_queue.sv
design/asfp_back.sv
design/actuator_status_frame_parser.sv
sim/tb_actuator_status_frame_parser.sv
